// ===== rtl/core/totp_pkg.sv =====
// ----------------------------------------------------------------------------
// totp_pkg
// Shared types, constants and SHA-1 round functions for the TOTP generator.
// ----------------------------------------------------------------------------
package totp_pkg;

   localparam int KEY_BYTES         = 32;
   localparam int SECONDS_W         = 40;
   localparam int OFFSET_W          = 3;
   localparam int CODE_W            = 27;
   localparam int ROUNDS            = 80;
   localparam int DIV_CELLS         = 5;
   localparam int DIV_BITS_PER_CELL = 8;
   localparam int REM_W             = 5;
   localparam int CTR_W             = 41;
   localparam int AUX_W             = 160;

   localparam logic [5:0]  STEP_SECONDS = 6'd30;
   localparam logic [30:0] CODE_MODULUS = 31'd100000000;
   localparam logic [7:0]  IPAD_BYTE    = 8'h36;
   localparam logic [7:0]  OPAD_BYTE    = 8'h5c;

   typedef logic [31:0] word_type;

   typedef struct packed {
      word_type a;
      word_type b;
      word_type c;
      word_type d;
      word_type e;
   } sha_state_type;

   localparam sha_state_type SHA_IV = '{
      a: 32'h67452301, b: 32'hefcdab89, c: 32'h98badcfe,
      d: 32'h10325476, e: 32'hc3d2e1f0};

   localparam word_type PAD_WORD     = 32'h80000000;
   localparam word_type INNER_LENGTH = 32'd576;
   localparam word_type OUTER_LENGTH = 32'd672;

   typedef struct packed {
      sha_state_type     st;
      sha_state_type     cv;
      word_type [15:0]   w;
      logic [AUX_W-1:0]  aux;
   } round_data_type;

   typedef struct packed {
      logic [SECONDS_W-1:0] num;
      logic [SECONDS_W-1:0] quo;
      logic [REM_W-1:0]     rem;
      logic [OFFSET_W-1:0]  off;
   } div_data_type;

   function automatic word_type rotl1(input word_type x);
      return {x[30:0], x[31]};
   endfunction

   function automatic word_type sched_next(input word_type [15:0] w);
      return rotl1(w[13] ^ w[8] ^ w[2] ^ w[0]);
   endfunction

   function automatic sha_state_type sha_round(input sha_state_type s, input word_type w,
                                               input logic [6:0] idx);
      word_type      f;
      word_type      k;
      sha_state_type r;
      if (idx < 7'd20) begin
         f = (s.b & s.c) | (~s.b & s.d);
         k = 32'h5a827999;
      end else if (idx < 7'd40) begin
         f = s.b ^ s.c ^ s.d;
         k = 32'h6ed9eba1;
      end else if (idx < 7'd60) begin
         f = (s.b & s.c) | (s.b & s.d) | (s.c & s.d);
         k = 32'h8f1bbcdc;
      end else begin
         f = s.b ^ s.c ^ s.d;
         k = 32'hca62c1d6;
      end
      r.a = {s.a[26:0], s.a[31:27]} + f + s.e + k + w;
      r.b = s.a;
      r.c = {s.b[1:0], s.b[31:2]};
      r.d = s.c;
      r.e = s.d;
      return r;
   endfunction

   // key padded to 64 bytes, bytes at or past KEY_BYTES zeroed, then xor pad
   function automatic word_type [15:0] pad_block(input logic [255:0] key,
                                                 input logic [7:0] pad);
      word_type [15:0] blk;
      logic [7:0]      kb;
      for (int i = 0; i < 64; i++) begin
         kb = 8'h00;
         if (i < KEY_BYTES && i < 32)
            kb = key[255-8*i -: 8];
         blk[i/4][31-8*(i%4) -: 8] = kb ^ pad;
      end
      return blk;
   endfunction

endpackage

// ===== rtl/core/totp_req_if.sv =====
// ----------------------------------------------------------------------------
// totp_req_if
// Request channel: time in seconds and window offset.
// ----------------------------------------------------------------------------
interface totp_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [totp_pkg::SECONDS_W-1:0]       unix_seconds;
   logic signed [totp_pkg::OFFSET_W-1:0] time_offset;

   modport source (output valid, output unix_seconds, output time_offset, input ready);
   modport sink   (input valid, input unix_seconds, input time_offset, output ready);
endinterface

// ===== rtl/core/totp_rsp_if.sv =====
// ----------------------------------------------------------------------------
// totp_rsp_if
// Response channel: eight-digit code.
// ----------------------------------------------------------------------------
interface totp_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [totp_pkg::CODE_W-1:0]  otp_code;

   modport source (output valid, output otp_code, input ready);
   modport sink   (input valid, input otp_code, output ready);
endinterface

// ===== rtl/core/totp_div_cell.sv =====
// ----------------------------------------------------------------------------
// totp_div_cell
// Divide-by-30 cell: eight restoring quotient bits per word, one stage.
// ----------------------------------------------------------------------------
module totp_div_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  totp_pkg::div_data_type  in_data,
   output logic                    out_valid,
   input  logic                    out_ready,
   output totp_pkg::div_data_type  out_data
);

   logic                   valid_ff;
   totp_pkg::div_data_type data_ff;
   totp_pkg::div_data_type data_in;

   always_comb begin
      logic [totp_pkg::REM_W:0] t;
      data_in = in_data;
      for (int j = 0; j < totp_pkg::DIV_BITS_PER_CELL; j++) begin
         t = {data_in.rem, data_in.num[totp_pkg::SECONDS_W-1]};
         data_in.num = {data_in.num[totp_pkg::SECONDS_W-2:0], 1'b0};
         if (t >= totp_pkg::STEP_SECONDS) begin
            data_in.rem = totp_pkg::REM_W'(t - totp_pkg::STEP_SECONDS);
            data_in.quo = {data_in.quo[totp_pkg::SECONDS_W-2:0], 1'b1};
         end else begin
            data_in.rem = t[totp_pkg::REM_W-1:0];
            data_in.quo = {data_in.quo[totp_pkg::SECONDS_W-2:0], 1'b0};
         end
      end
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

// ===== rtl/core/totp_round_cell.sv =====
// ----------------------------------------------------------------------------
// totp_round_cell
// One SHA-1 round with a rolling 16-word message schedule window.
// ----------------------------------------------------------------------------
module totp_round_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [6:0]                round_idx,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  totp_pkg::round_data_type  in_data,
   output logic                      out_valid,
   input  logic                      out_ready,
   output totp_pkg::round_data_type  out_data
);

   logic                     valid_ff;
   totp_pkg::round_data_type data_ff;
   totp_pkg::round_data_type data_in;

   always_comb begin
      data_in    = in_data;
      data_in.st = totp_pkg::sha_round(in_data.st, in_data.w[0], round_idx);
      data_in.w  = {totp_pkg::sched_next(in_data.w), in_data.w[15:1]};
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

// ===== rtl/core/totp_sha1_block.sv =====
// ----------------------------------------------------------------------------
// totp_sha1_block
// One SHA-1 compression: a chain of 80 round cells plus the chaining add.
// ----------------------------------------------------------------------------
module totp_sha1_block (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  totp_pkg::sha_state_type       in_cv,
   input  totp_pkg::word_type [15:0]     in_block,
   input  logic [totp_pkg::AUX_W-1:0]    in_aux,
   output logic                          out_valid,
   input  logic                          out_ready,
   output totp_pkg::sha_state_type       out_digest,
   output logic [totp_pkg::AUX_W-1:0]    out_aux
);

   totp_pkg::round_data_type chain_data  [totp_pkg::ROUNDS+1];
   logic                     chain_valid [totp_pkg::ROUNDS+1];
   logic                     chain_ready [totp_pkg::ROUNDS+1];
   totp_pkg::round_data_type last;

   assign chain_data[0]  = '{st: in_cv, cv: in_cv, w: in_block, aux: in_aux};
   assign chain_valid[0] = in_valid;
   assign in_ready       = chain_ready[0];

   for (genvar i = 0; i < totp_pkg::ROUNDS; i++) begin : g_round
      totp_round_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .round_idx (7'(i)),
         .in_valid  (chain_valid[i]),
         .in_ready  (chain_ready[i]),
         .in_data   (chain_data[i]),
         .out_valid (chain_valid[i+1]),
         .out_ready (chain_ready[i+1]),
         .out_data  (chain_data[i+1])
      );
   end

   assign chain_ready[totp_pkg::ROUNDS] = out_ready;
   assign out_valid = chain_valid[totp_pkg::ROUNDS];
   assign last      = chain_data[totp_pkg::ROUNDS];

   assign out_digest.a = last.cv.a + last.st.a;
   assign out_digest.b = last.cv.b + last.st.b;
   assign out_digest.c = last.cv.c + last.st.c;
   assign out_digest.d = last.cv.d + last.st.d;
   assign out_digest.e = last.cv.e + last.st.e;
   assign out_aux      = last.aux;

endmodule

// ===== rtl/core/totp_code_generator.sv =====
// ----------------------------------------------------------------------------
// totp_code_generator
// TOTP code generator: HMAC-SHA1 over the 30 s time step, 8-digit code.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries unix_seconds and time_offset; rsp_bus returns otp_code.
//   Both are valid/ready channels; a word moves when valid and ready are high.
//   The 256-bit secret sits in four 64-bit CSRs at byte addresses 0, 8, 16, 24
//   (key byte 0 in bit 63 of word 0). Write the key while no request is open.
// Pipeline: 5 divide cells, 4 x 80 SHA-1 round cells, a truncation stage and
//   the output register.
// Throughput: one word per cycle; every cell takes a new word each cycle while
//   its successor moves or is empty.
// Stall: while rsp_bus.ready is low, words pack into empty cells behind the
//   output register; req_bus.ready drops once the whole chain is full.
// Reset: all cells empty, key registers cleared to zero.
// ----------------------------------------------------------------------------
module totp_code_generator (
   input  logic        clock,
   input  logic        reset,
   totp_req_if.sink    req_bus,
   totp_rsp_if.source  rsp_bus,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);

   localparam logic [1:0] REG_KEY_WORD_0 = 2'd0;
   localparam logic [1:0] REG_KEY_WORD_1 = 2'd1;
   localparam logic [1:0] REG_KEY_WORD_2 = 2'd2;
   localparam logic [1:0] REG_KEY_WORD_3 = 2'd3;

   logic [63:0] key_ff [4];
   logic [1:0]  reg_idx;

   assign reg_idx    = csr_paddr[4:3];
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) key_ff[i] <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         key_ff[reg_idx] <= csr_pwdata;
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_KEY_WORD_0: csr_prdata = key_ff[0];
         REG_KEY_WORD_1: csr_prdata = key_ff[1];
         REG_KEY_WORD_2: csr_prdata = key_ff[2];
         REG_KEY_WORD_3: csr_prdata = key_ff[3];
         default:        csr_prdata = '0;
      endcase
   end

   logic [255:0]              key_all;
   totp_pkg::word_type [15:0] ipad_blk;
   totp_pkg::word_type [15:0] opad_blk;

   assign key_all  = {key_ff[0], key_ff[1], key_ff[2], key_ff[3]};
   assign ipad_blk = totp_pkg::pad_block(key_all, totp_pkg::IPAD_BYTE);
   assign opad_blk = totp_pkg::pad_block(key_all, totp_pkg::OPAD_BYTE);

   // divide by 30
   totp_pkg::div_data_type div_data  [totp_pkg::DIV_CELLS+1];
   logic                   div_valid [totp_pkg::DIV_CELLS+1];
   logic                   div_ready [totp_pkg::DIV_CELLS+1];

   assign div_data[0]   = '{num: req_bus.unix_seconds, quo: '0, rem: '0,
                            off: req_bus.time_offset};
   assign div_valid[0]  = req_bus.valid;
   assign req_bus.ready = div_ready[0];

   for (genvar i = 0; i < totp_pkg::DIV_CELLS; i++) begin : g_div
      totp_div_cell u_div (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (div_valid[i]),
         .in_ready  (div_ready[i]),
         .in_data   (div_data[i]),
         .out_valid (div_valid[i+1]),
         .out_ready (div_ready[i+1]),
         .out_data  (div_data[i+1])
      );
   end

   // counter with offset, clamped at zero
   totp_pkg::div_data_type     div_out;
   logic [2:0]                 off_mag;
   logic [totp_pkg::CTR_W-1:0] ctr;

   assign div_out = div_data[totp_pkg::DIV_CELLS];
   assign off_mag = 3'(~div_out.off + 3'd1);

   always_comb begin
      if (div_out.off[2]) begin
         if (div_out.quo >= totp_pkg::SECONDS_W'(off_mag))
            ctr = totp_pkg::CTR_W'(div_out.quo - totp_pkg::SECONDS_W'(off_mag));
         else
            ctr = '0;
      end else begin
         ctr = totp_pkg::CTR_W'(div_out.quo) + totp_pkg::CTR_W'(div_out.off[1:0]);
      end
   end

   // four compressions: ipad, inner message, opad, outer message
   logic                          b_valid [5];
   logic                          b_ready [5];
   totp_pkg::sha_state_type       b_digest [4];
   logic [totp_pkg::AUX_W-1:0]    b_aux [4];
   totp_pkg::sha_state_type       b_cv [4];
   totp_pkg::word_type [15:0]     b_blk [4];
   logic [totp_pkg::AUX_W-1:0]    b_aux_in [4];
   logic [63:0]                   ctr64;
   totp_pkg::sha_state_type       inner;

   assign ctr64            = 64'(ctr);
   assign b_valid[0]       = div_valid[totp_pkg::DIV_CELLS];
   assign div_ready[totp_pkg::DIV_CELLS] = b_ready[0];

   assign b_cv[0]     = totp_pkg::SHA_IV;
   assign b_blk[0]    = ipad_blk;
   assign b_aux_in[0] = totp_pkg::AUX_W'(ctr64);

   assign b_cv[1]     = b_digest[0];
   assign b_blk[1]    = {totp_pkg::INNER_LENGTH, 32'h0, 352'h0, totp_pkg::PAD_WORD,
                         b_aux[0][31:0], b_aux[0][63:32]};
   assign b_aux_in[1] = '0;

   assign b_cv[2]     = totp_pkg::SHA_IV;
   assign b_blk[2]    = opad_blk;
   assign b_aux_in[2] = b_digest[1];

   assign inner       = b_aux[2];
   assign b_cv[3]     = b_digest[2];
   assign b_blk[3]    = {totp_pkg::OUTER_LENGTH, 32'h0, 256'h0, totp_pkg::PAD_WORD,
                         inner.e, inner.d, inner.c, inner.b, inner.a};
   assign b_aux_in[3] = '0;

   for (genvar i = 0; i < 4; i++) begin : g_blk
      totp_sha1_block u_blk (
         .clock      (clock),
         .reset      (reset),
         .in_valid   (b_valid[i]),
         .in_ready   (b_ready[i]),
         .in_cv      (b_cv[i]),
         .in_block   (b_blk[i]),
         .in_aux     (b_aux_in[i]),
         .out_valid  (b_valid[i+1]),
         .out_ready  (b_ready[i+1]),
         .out_digest (b_digest[i]),
         .out_aux    (b_aux[i])
      );
   end

   // dynamic truncation
   logic          trunc_valid_ff;
   logic [30:0]   trunc_ff;
   logic          trunc_ready;
   logic [159:0]  mac;
   logic [159:0]  mac_sh;
   logic          out_ready;

   assign mac         = b_digest[3];
   assign mac_sh      = mac << {mac[3:0], 3'b000};
   assign trunc_ready = !trunc_valid_ff || out_ready;
   assign b_ready[4]  = trunc_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         trunc_valid_ff <= 1'b0;
      end else if (trunc_ready) begin
         trunc_valid_ff <= b_valid[4];
      end
      if (trunc_ready && b_valid[4]) begin
         trunc_ff <= mac_sh[158:128];
      end
   end

   // modulo 10^8 by conditional subtraction of 16, 8, 4, 2, 1 x 10^8
   logic                        rsp_valid_ff;
   logic [totp_pkg::CODE_W-1:0] code_ff;
   logic [30:0]                 code_in;

   always_comb begin
      logic [30:0] step;
      code_in = trunc_ff;
      for (int j = 4; j >= 0; j--) begin
         step = totp_pkg::CODE_MODULUS << j;
         if (code_in >= step) code_in = code_in - step;
      end
   end

   assign out_ready        = !rsp_valid_ff || rsp_bus.ready;
   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.otp_code = code_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= trunc_valid_ff;
      end
      if (out_ready && trunc_valid_ff) begin
         code_ff <= code_in[totp_pkg::CODE_W-1:0];
      end
   end

endmodule
